[rtl/atrt_pkg.sv]
// Shared codes and types for the ack timeout retry tracker.
package atrt_pkg;

	// Command codes
	localparam logic [2:0] CMD_PUSH  = 3'd0;
	localparam logic [2:0] CMD_ACK   = 3'd1;
	localparam logic [2:0] CMD_TICK  = 3'd2;
	localparam logic [2:0] CMD_POP   = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_MISS  = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;
	localparam logic [1:0] STS_EMPTY = 2'd3;

	// Register indexes
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_MAXR    = 1'b1;

	localparam logic [31:0] TIMEOUT_RST = 32'd1000;
	localparam logic [3:0]  MAXR_RST    = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

[rtl/atrt_cell.sv]
// One slot of the pending list: loads an entry or takes its right neighbor's.
module atrt_cell #(
	parameter int EW = 84
) (
	input  logic                  clk,
	input  atrt_pkg::cell_ctl_t   ctl,
	input  logic [EW-1:0]         d_load,
	input  logic [EW-1:0]         d_right,
	output logic [EW-1:0]         q
);
	import atrt_pkg::*;

	logic [EW-1:0] entry_q;

	// load wins over the shift
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= d_load;
		end else if (ctl.shift) begin
			entry_q <= d_right;
		end
	end

	assign q = entry_q;

endmodule

[rtl/ack_timeout_retry_tracker_unit.sv]
// Top level of the ack timeout retry tracker: sequencer, cell chain, retry FIFO.
//
// Push, pop, clear and unknown commands are accepted with start, and done pulses
// in the next cycle. Ack and tick walk the pending list, one entry per cycle
// as the chain of cells shifts toward slot 0; with an empty list they finish
// like the other commands. busy is high during the walk. Each result is shown
// for exactly one cycle with done and cannot be held off. pending_count holds
// the list size from before a walk until the walk ends, and equals the step's
// result when done is high.
module ack_timeout_retry_tracker_unit #(
	parameter int POOL_DEPTH   = 16,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	output logic                              done,
	input  logic [2:0]                        cmd,
	input  logic [KEY_BITS-1:0]               key,
	input  logic [PAYLOAD_BITS-1:0]           payload,
	input  logic [3:0]                        retries_in,
	input  logic [31:0]                       now_ms,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [31:0]                       cfg_wdata,
	output logic [1:0]                        status,
	output logic [KEY_BITS-1:0]               key_out,
	output logic [PAYLOAD_BITS-1:0]           payload_out,
	output logic [3:0]                        retries_out,
	output logic [$clog2(POOL_DEPTH+1)-1:0]   moved_count,
	output logic [$clog2(POOL_DEPTH+1)-1:0]   pending_count
);
	import atrt_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int EW = KEY_BITS + PAYLOAD_BITS + 32 + 4;
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(POOL_DEPTH);
	localparam logic [AW:0] DEPTH_A = (AW + 1)'(POOL_DEPTH);

	state_t state_q;
	logic [CW-1:0] n_q, fill_q, s_q, d_q, moved_q;
	logic [AW-1:0] rd_q;
	logic found_q, done_q, walk_ack_q;
	logic [1:0] status_q;
	logic [31:0] timeout_q;
	logic [3:0] maxr_q;
	logic [KEY_BITS-1:0] key_q;
	logic [31:0] now_q;

	logic [EW-1:0] cell_q [POOL_DEPTH];
	logic [EW-1:0] push_entry, head;
	logic [KEY_BITS-1:0] head_key;
	logic [PAYLOAD_BITS-1:0] head_pl;
	logic [31:0] head_time, elapsed;
	logic [3:0] head_ret;
	logic in_walk, accept, push_wr, drop, app, ins, last, expired;
	logic [CW-1:0] ins_idx;
	logic [AW+1:0] wsum;
	logic [AW-1:0] wptr;

	// Retry FIFO storage
	logic [KEY_BITS-1:0]     rkey_mem [POOL_DEPTH];
	logic [PAYLOAD_BITS-1:0] rpl_mem  [POOL_DEPTH];
	logic [3:0]              rcnt_mem [POOL_DEPTH];
	logic [KEY_BITS-1:0]     kout_q;
	logic [PAYLOAD_BITS-1:0] pout_q;
	logic [3:0]              rout_q;

	assign accept  = start && (state_q == ST_IDLE);
	assign in_walk = (state_q == ST_WALK);
	assign push_wr = accept && (cmd == CMD_PUSH)
		&& (({1'b0, n_q} + {1'b0, fill_q}) < DEPTH_W);
	assign push_entry = {key, payload, now_ms, retries_in};

	// Head of the chain and its verdict
	assign head = cell_q[0];
	assign {head_key, head_pl, head_time, head_ret} = head;
	assign elapsed = now_q - head_time;
	assign expired = (elapsed >= timeout_q);
	assign drop = in_walk && (walk_ack_q ? (!found_q && head_key == key_q) : expired);
	assign app = in_walk && !walk_ack_q && expired && (head_ret < maxr_q)
		&& ({1'b0, fill_q} < DEPTH_W);
	assign ins = in_walk && !drop;
	assign ins_idx = n_q - CW'(1) - d_q;
	assign last = (s_q == n_q - CW'(1));

	// Write slot of the retry FIFO
	assign wsum = (AW + 2)'(rd_q) + (AW + 2)'(fill_q);
	assign wptr = (wsum >= (AW + 2)'(DEPTH_A)) ? AW'(wsum - (AW + 2)'(DEPTH_A)) : AW'(wsum);

	// Chain of cells
	for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		logic [EW-1:0] right;
		if (i == POOL_DEPTH - 1) begin : g_end
			assign right = cell_q[i];
		end else begin : g_mid
			assign right = cell_q[i+1];
		end
		assign ctl.load  = (push_wr && n_q == CW'(i)) || (ins && ins_idx == CW'(i));
		assign ctl.shift = in_walk;
		atrt_cell #(.EW(EW)) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.d_load  (in_walk ? head : push_entry),
			.d_right (right),
			.q       (cell_q[i])
		);
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			n_q        <= '0;
			fill_q     <= '0;
			rd_q       <= '0;
			s_q        <= '0;
			d_q        <= '0;
			moved_q    <= '0;
			found_q    <= 1'b0;
			walk_ack_q <= 1'b0;
			status_q   <= STS_OK;
			timeout_q  <= TIMEOUT_RST;
			maxr_q     <= MAXR_RST;
			key_q      <= '0;
			now_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_TIMEOUT: timeout_q <= cfg_wdata;
					REG_MAXR:    maxr_q <= cfg_wdata[3:0];
					default:     ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q   <= STS_OK;
						moved_q    <= '0;
						s_q        <= '0;
						d_q        <= '0;
						found_q    <= 1'b0;
						walk_ack_q <= (cmd == CMD_ACK);
						key_q      <= key;
						now_q      <= now_ms;
						done_q     <= 1'b1;
						unique case (cmd)
							CMD_PUSH: begin
								if (push_wr) begin
									n_q <= n_q + CW'(1);
								end else begin
									status_q <= STS_FULL;
								end
							end
							CMD_ACK: begin
								if (n_q == '0) begin
									status_q <= STS_MISS;
								end else begin
									done_q  <= 1'b0;
									state_q <= ST_WALK;
								end
							end
							CMD_TICK: begin
								if (n_q != '0) begin
									done_q  <= 1'b0;
									state_q <= ST_WALK;
								end
							end
							CMD_POP: begin
								if (fill_q == '0) begin
									status_q <= STS_EMPTY;
								end else begin
									rd_q   <= (rd_q == AW'(POOL_DEPTH - 1)) ? '0 : rd_q + AW'(1);
									fill_q <= fill_q - CW'(1);
								end
							end
							CMD_CLEAR: begin
								n_q    <= '0;
								fill_q <= '0;
								rd_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					s_q <= s_q + CW'(1);
					if (drop) begin
						d_q     <= d_q + CW'(1);
						found_q <= walk_ack_q;
					end
					if (app) begin
						fill_q  <= fill_q + CW'(1);
						moved_q <= moved_q + CW'(1);
					end
					if (last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						n_q     <= n_q - d_q - CW'(drop);
						if (walk_ack_q && !found_q && !drop) begin
							status_q <= STS_MISS;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Retry FIFO write and registered pop read
	always_ff @(posedge clk) begin
		if (app) begin
			rkey_mem[wptr] <= head_key;
			rpl_mem[wptr]  <= head_pl;
			rcnt_mem[wptr] <= head_ret + 4'd1;
		end
		if (accept) begin
			if (cmd == CMD_POP && fill_q != '0) begin
				kout_q <= rkey_mem[rd_q];
				pout_q <= rpl_mem[rd_q];
				rout_q <= rcnt_mem[rd_q];
			end else begin
				kout_q <= '0;
				pout_q <= '0;
				rout_q <= '0;
			end
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign key_out       = kout_q;
	assign payload_out   = pout_q;
	assign retries_out   = rout_q;
	assign moved_count   = moved_q;
	assign pending_count = n_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while walking");
	// n_q still counts moved entries until the walk ends
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_walk |-> (({1'b0, n_q} + {1'b0, fill_q}) <= DEPTH_W))
		else $error("pool overfilled");
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_walk |-> (n_q != '0)) else $error("walk over empty list");
	a_drop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_walk |-> (d_q <= s_q)) else $error("more drops than steps");

endmodule

[tb/sv/tb_ack_timeout_retry_tracker_unit.sv]
// Self-checking testbench for the ack timeout retry tracker top level.
module tb_ack_timeout_retry_tracker_unit;
	import atrt_pkg::*;

	localparam int DEPTH = 16;

	typedef struct {
		logic [2:0]  cmd;
		logic [31:0] key;
		logic [15:0] payload;
		logic [3:0]  rin;
		logic [31:0] now;
	} cmd_item_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] key;
		logic [15:0] payload;
		logic [3:0]  retries;
		logic [4:0]  moved;
		logic [4:0]  pending;
	} tracker_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic [2:0]  cmd = CMD_CLEAR;
	logic [31:0] key = '0;
	logic [15:0] payload = '0;
	logic [3:0]  retries_in = '0;
	logic [31:0] now_ms = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = REG_TIMEOUT;
	logic [31:0] cfg_wdata = '0;
	logic [1:0]  status;
	logic [31:0] key_out;
	logic [15:0] payload_out;
	logic [3:0]  retries_out;
	logic [4:0]  moved_count;
	logic [4:0]  pending_count;

	cmd_item_t       cmd_queue[$];
	tracker_result_t result_queue[$];
	int              errors = 0;
	int              gap = 0;
	bit              quiet = 1'b0;

	// shadow copy of the tracker state
	logic [31:0] sh_timeout;
	logic [3:0]  sh_maxr;
	logic [31:0] pl_key[DEPTH];
	logic [15:0] pl_payload[DEPTH];
	logic [31:0] pl_time[DEPTH];
	logic [3:0]  pl_retries[DEPTH];
	int          pl_count;
	logic [31:0] rq_key[DEPTH];
	logic [15:0] rq_payload[DEPTH];
	logic [3:0]  rq_retries[DEPTH];
	int          rq_rd;
	int          rq_fill;

	ack_timeout_retry_tracker_unit DUT (.*);

	always #4 clk = ~clk;

	// expected result of one command, updating the shadow state
	task automatic track_command(input cmd_item_t it);
		tracker_result_t r;
		int              i;
		int              w;
		int              wp;
		logic [31:0]     elapsed;
		r = '{STS_OK, '0, '0, '0, '0, '0};
		case (it.cmd)
			CMD_PUSH: begin
				if (pl_count + rq_fill >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					pl_key[pl_count]     = it.key;
					pl_payload[pl_count] = it.payload;
					pl_time[pl_count]    = it.now;
					pl_retries[pl_count] = it.rin;
					pl_count++;
				end
			end
			CMD_ACK: begin
				r.status = STS_MISS;
				for (i = 0; i < pl_count; i++) begin
					if (pl_key[i] == it.key) begin
						for (w = i; w + 1 < pl_count; w++) begin
							pl_key[w]     = pl_key[w+1];
							pl_payload[w] = pl_payload[w+1];
							pl_time[w]    = pl_time[w+1];
							pl_retries[w] = pl_retries[w+1];
						end
						pl_count--;
						r.status = STS_OK;
						break;
					end
				end
			end
			CMD_TICK: begin
				w = 0;
				for (i = 0; i < pl_count; i++) begin
					elapsed = it.now - pl_time[i];
					if (elapsed >= sh_timeout) begin
						if (pl_retries[i] < sh_maxr && rq_fill < DEPTH) begin
							wp = (rq_rd + rq_fill) % DEPTH;
							rq_key[wp]     = pl_key[i];
							rq_payload[wp] = pl_payload[i];
							rq_retries[wp] = pl_retries[i] + 4'd1;
							rq_fill++;
							r.moved++;
						end
					end else begin
						pl_key[w]     = pl_key[i];
						pl_payload[w] = pl_payload[i];
						pl_time[w]    = pl_time[i];
						pl_retries[w] = pl_retries[i];
						w++;
					end
				end
				pl_count = w;
			end
			CMD_POP: begin
				if (rq_fill == 0) begin
					r.status = STS_EMPTY;
				end else begin
					r.key     = rq_key[rq_rd];
					r.payload = rq_payload[rq_rd];
					r.retries = rq_retries[rq_rd];
					rq_rd     = (rq_rd + 1) % DEPTH;
					rq_fill--;
				end
			end
			CMD_CLEAR: begin
				pl_count = 0;
				rq_rd    = 0;
				rq_fill  = 0;
			end
			default: ;
		endcase
		r.pending = pl_count[4:0];
		result_queue.push_back(r);
	endtask

	// driver: holds start until accepted, random idle bursts between items
	always @(posedge clk) begin
		cmd_item_t it;
		if (arst_n) begin
			if (start && !busy)
				track_command('{cmd, key, payload, retries_in, now_ms});
			if (start && busy) begin
				// still waiting for acceptance
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (cmd_queue.size() > 0) begin
				it = cmd_queue.pop_front();
				cmd <= it.cmd;
				key <= it.key;
				payload <= it.payload;
				retries_in <= it.rin;
				now_ms <= it.now;
				start <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					gap <= $urandom_range(1, 8);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		tracker_result_t e;
		if (arst_n && done) begin
			if (result_queue.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				errors++;
			end else begin
				e = result_queue.pop_front();
				if (status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (key_out !== e.key) begin
					$display("%0t: key_out exp %h got %h", $time, e.key, key_out);
					errors++;
				end
				if (payload_out !== e.payload) begin
					$display("%0t: payload_out exp %h got %h", $time, e.payload,
						payload_out);
					errors++;
				end
				if (retries_out !== e.retries) begin
					$display("%0t: retries_out exp %0d got %0d", $time, e.retries,
						retries_out);
					errors++;
				end
				if (moved_count !== e.moved) begin
					$display("%0t: moved_count exp %0d got %0d", $time, e.moved,
						moved_count);
					errors++;
				end
				if (pending_count !== e.pending) begin
					$display("%0t: pending_count exp %0d got %0d", $time, e.pending,
						pending_count);
					errors++;
				end
			end
		end
	end

	task automatic add_cmd(input logic [2:0] c, input logic [31:0] k,
		input logic [15:0] p, input logic [3:0] r, input logic [31:0] t);
		cmd_queue.push_back('{c, k, p, r, t});
	endtask

	// wait for the block to go idle, then write both registers
	task automatic set_config(input logic [31:0] tmo, input logic [3:0] maxr);
		while (cmd_queue.size() > 0 || start || result_queue.size() > 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_idx <= REG_MAXR;
		cfg_wdata <= {28'd0, maxr};
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_timeout = tmo;
		sh_maxr = maxr;
	endtask

	// mostly realistic traffic on a small key set with advancing time
	task automatic random_phase(input int n, input logic [31:0] t0);
		logic [31:0] t;
		logic [31:0] k;
		int          sel;
		int          step;
		t = t0;
		step = (sh_timeout == 0) ? 10 : (sh_timeout > 2000) ? 2000 : sh_timeout;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			t = t + $urandom_range(0, step / 2);
			k = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
			if ($urandom_range(0, 19) == 0)
				t = $urandom;
			if (sel < 40)
				add_cmd(CMD_PUSH, k, $urandom, $urandom, t);
			else if (sel < 60)
				add_cmd(CMD_ACK, k, $urandom, $urandom, t);
			else if (sel < 78)
				add_cmd(CMD_TICK, $urandom, $urandom, $urandom, t);
			else if (sel < 95)
				add_cmd(CMD_POP, $urandom, $urandom, $urandom, t);
			else if (sel < 97)
				add_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, t);
			else
				add_cmd($urandom_range(5, 7), $urandom, $urandom, $urandom, t);
		end
	endtask

	// stimulus sequence
	initial begin
		int i;
		sh_timeout = TIMEOUT_RST;
		sh_maxr = MAXR_RST;
		pl_count = 0;
		rq_rd = 0;
		rq_fill = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ack hit and miss, expiry, discard, empty pop
		set_config(32'd0, 4'd15);
		add_cmd(CMD_POP, '0, '0, '0, '0);
		add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
		add_cmd(CMD_PUSH, 32'h0, 16'h0, 4'd0, 32'h0);
		add_cmd(CMD_PUSH, 32'h5, 16'h1234, 4'd14, 32'h10);
		add_cmd(CMD_ACK, 32'h7, '0, '0, '0);
		add_cmd(CMD_ACK, 32'h0, '0, '0, '0);
		add_cmd(CMD_TICK, '0, '0, '0, 32'h5);
		add_cmd(CMD_POP, '0, '0, '0, '0);
		add_cmd(CMD_POP, '0, '0, '0, '0);
		for (i = 5; i < 8; i++)
			add_cmd(i[2:0], 32'hA5A5_5A5A, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
		// fill the pool, then a refused push
		for (i = 0; i < 17; i++)
			add_cmd(CMD_PUSH, i, i, i, 32'd100);
		add_cmd(CMD_CLEAR, '0, '0, '0, '0);

		set_config(32'd1000, 4'd3);
		random_phase(260, 32'd0);
		set_config(32'd0, 4'd0);
		random_phase(200, 32'h1234_0000);
		set_config(32'd50, 4'd15);
		random_phase(260, 32'hFFFF_F000);
		set_config(32'hFFFF_FFFF, 4'd1);
		add_cmd(CMD_PUSH, 32'h9, 16'h9, 4'd0, 32'd1);
		add_cmd(CMD_TICK, '0, '0, '0, 32'd0);
		add_cmd(CMD_POP, '0, '0, '0, '0);
		random_phase(150, 32'd77);
		set_config($urandom_range(1, 300), $urandom_range(0, 15));
		random_phase(200, $urandom);
		quiet = 1'b1;
		random_phase(200, $urandom);

		while (cmd_queue.size() > 0 || start || result_queue.size() > 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (errors == 0 && result_queue.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

endmodule
